// File: rtl/spherical_camera_controller_defines.svh
// ---------------------------------------------------------------------------
// Spherical camera controller assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during rst_ni.
// ---------------------------------------------------------------------------
`ifndef SPHERICAL_CAMERA_CONTROLLER_DEFINES_SVH
`define SPHERICAL_CAMERA_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define SCC_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
`define SCC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SCC_ASSERT(lbl, pre, post)
`define SCC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: rtl/scc_pkg.sv
// ---------------------------------------------------------------------------
// Spherical camera controller package
// Widths, constants, datapath command codes and shared types.
// ---------------------------------------------------------------------------
package scc_pkg;

  localparam int XW  = 58;
  localparam int ZW  = 30;
  localparam int MAW = 37;
  localparam int MBW = 25;
  localparam int PW  = 62;
  localparam int RW  = 40;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic signed [ZW-1:0] PI_Q24      = 30'sd52707179;
  localparam logic signed [MBW-1:0] INVK_Q24   = 25'sd10188014;
  localparam logic signed [XW-1:0] INVK_Q30    = 58'sd652032874;
  localparam logic signed [19:0] PI_Q13        = 20'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13   = 16'sd12868;
  localparam logic signed [XW-1:0] ONE_Q14     = 58'sd16384;

  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_CAPTURE    = 4'd1;
  localparam logic [3:0] OP_LOAD       = 4'd2;
  localparam logic [3:0] OP_V1_INIT    = 4'd3;
  localparam logic [3:0] OP_V2_INIT    = 4'd4;
  localparam logic [3:0] OP_ITER       = 4'd5;
  localparam logic [3:0] OP_SAVE_T     = 4'd6;
  localparam logic [3:0] OP_REFRESH    = 4'd7;
  localparam logic [3:0] OP_SA_INIT    = 4'd8;
  localparam logic [3:0] OP_SE_INIT    = 4'd9;
  localparam logic [3:0] OP_SA_FIN     = 4'd10;
  localparam logic [3:0] OP_SE_FIN     = 4'd11;
  localparam logic [3:0] OP_MOVE       = 4'd12;
  localparam logic [3:0] OP_REBUILD    = 4'd13;
  localparam logic [3:0] OP_OUT        = 4'd14;

  localparam logic [2:0] MS_UNSCALE = 3'd0;
  localparam logic [2:0] MS_STEP_ST = 3'd1;
  localparam logic [2:0] MS_STEP_CT = 3'd2;
  localparam logic [2:0] MS_STEP_SP = 3'd3;
  localparam logic [2:0] MS_DIST_SP = 3'd4;
  localparam logic [2:0] MS_DIST_CP = 3'd5;
  localparam logic [2:0] MS_COSP_CT = 3'd6;
  localparam logic [2:0] MS_COSP_ST = 3'd7;

  localparam logic [4:0] FN_REFRESH = 5'd2;
  localparam logic [4:0] FN_EYE_LO  = 5'd3;
  localparam logic [4:0] FN_TGT_LO  = 5'd9;
  localparam logic [4:0] FN_TGT_HI  = 5'd14;
  localparam logic [4:0] FN_FPS     = 5'd15;
  localparam logic [4:0] FN_TPS     = 5'd16;

  typedef struct packed {
    logic [3:0] op;
    logic       mul_en;
    logic [2:0] msel;
    logic       save_en;
    logic [1:0] save_slot;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_last;
    logic is_load;
    logic is_refresh;
    logic is_move;
    logic is_rebuild;
  } dp_status_t;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] step;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } cmd_item_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [31:0]        view_range;
    logic signed [15:0] elevation_out;
    logic signed [15:0] azimuth_out;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } res_item_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 30'sd13176795;
      5'd1:  v = 30'sd7778716;
      5'd2:  v = 30'sd4110060;
      5'd3:  v = 30'sd2086331;
      5'd4:  v = 30'sd1047214;
      5'd5:  v = 30'sd524117;
      5'd6:  v = 30'sd262123;
      5'd7:  v = 30'sd131069;
      5'd8:  v = 30'sd65536;
      5'd9:  v = 30'sd32768;
      5'd10: v = 30'sd16384;
      5'd11: v = 30'sd8192;
      5'd12: v = 30'sd4096;
      5'd13: v = 30'sd2048;
      5'd14: v = 30'sd1024;
      5'd15: v = 30'sd512;
      5'd16: v = 30'sd256;
      5'd17: v = 30'sd128;
      5'd18: v = 30'sd64;
      5'd19: v = 30'sd32;
      5'd20: v = 30'sd16;
      5'd21: v = 30'sd8;
      5'd22: v = 30'sd4;
      5'd23: v = 30'sd2;
      default: v = 30'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/scc_if.sv
// ---------------------------------------------------------------------------
// Spherical camera controller channels
// Command, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface scc_cmd_if;
  logic               valid;
  logic               ready;
  logic [4:0]         func;
  logic signed [31:0] step;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  modport source (output valid, func, step, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, func, step, coord_x, coord_y, coord_z, output ready);
endinterface

interface scc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic [31:0]        view_range;
  logic signed [15:0] elevation_out;
  logic signed [15:0] azimuth_out;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  view_range, elevation_out, azimuth_out, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                view_range, elevation_out, azimuth_out, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface scc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/scc_ctrl.sv
// ---------------------------------------------------------------------------
// Spherical camera controller sequencer
// Steps the datapath through CORDIC passes, products and updates per word.
// ---------------------------------------------------------------------------
`include "spherical_camera_controller_defines.svh"

module scc_ctrl
  import scc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_V1_INIT  = 5'd2;
  localparam logic [4:0] S_V1_ITER  = 5'd3;
  localparam logic [4:0] S_V1_MUL   = 5'd4;
  localparam logic [4:0] S_V2_INIT  = 5'd5;
  localparam logic [4:0] S_V2_ITER  = 5'd6;
  localparam logic [4:0] S_V2_MUL   = 5'd7;
  localparam logic [4:0] S_V2_FIN   = 5'd8;
  localparam logic [4:0] S_TA_INIT  = 5'd9;
  localparam logic [4:0] S_TA_ITER  = 5'd10;
  localparam logic [4:0] S_TA_FIN   = 5'd11;
  localparam logic [4:0] S_TE_INIT  = 5'd12;
  localparam logic [4:0] S_TE_ITER  = 5'd13;
  localparam logic [4:0] S_TE_FIN   = 5'd14;
  localparam logic [4:0] S_MV0      = 5'd15;
  localparam logic [4:0] S_MV1      = 5'd16;
  localparam logic [4:0] S_MV2      = 5'd17;
  localparam logic [4:0] S_MV3      = 5'd18;
  localparam logic [4:0] S_MV_APPLY = 5'd19;
  localparam logic [4:0] S_RB0      = 5'd20;
  localparam logic [4:0] S_RB1      = 5'd21;
  localparam logic [4:0] S_RB2      = 5'd22;
  localparam logic [4:0] S_RB3      = 5'd23;
  localparam logic [4:0] S_RB4      = 5'd24;
  localparam logic [4:0] S_RB5      = 5'd25;
  localparam logic [4:0] S_RB_APPLY = 5'd26;
  localparam logic [4:0] S_OUT      = 5'd27;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.is_refresh) begin
          state_d = S_V1_INIT;
        end else begin
          if (status_i.is_load) begin
            cmd_o.op = OP_LOAD;
          end
          state_d = S_TA_INIT;
        end
      end
      S_V1_INIT: begin
        cmd_o.op = OP_V1_INIT;
        state_d  = S_V1_ITER;
      end
      S_V1_ITER: begin
        cmd_o.op = OP_ITER;
        if (status_i.iter_last) begin
          state_d = S_V1_MUL;
        end
      end
      S_V1_MUL: begin
        cmd_o.op     = OP_SAVE_T;
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = MS_UNSCALE;
        state_d      = S_V2_INIT;
      end
      S_V2_INIT: begin
        cmd_o.op = OP_V2_INIT;
        state_d  = S_V2_ITER;
      end
      S_V2_ITER: begin
        cmd_o.op = OP_ITER;
        if (status_i.iter_last) begin
          state_d = S_V2_MUL;
        end
      end
      S_V2_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = MS_UNSCALE;
        state_d      = S_V2_FIN;
      end
      S_V2_FIN: begin
        cmd_o.op = OP_REFRESH;
        state_d  = S_TA_INIT;
      end
      S_TA_INIT: begin
        cmd_o.op = OP_SA_INIT;
        state_d  = S_TA_ITER;
      end
      S_TA_ITER: begin
        cmd_o.op = OP_ITER;
        if (status_i.iter_last) begin
          state_d = S_TA_FIN;
        end
      end
      S_TA_FIN: begin
        cmd_o.op = OP_SA_FIN;
        state_d  = S_TE_INIT;
      end
      S_TE_INIT: begin
        cmd_o.op = OP_SE_INIT;
        state_d  = S_TE_ITER;
      end
      S_TE_ITER: begin
        cmd_o.op = OP_ITER;
        if (status_i.iter_last) begin
          state_d = S_TE_FIN;
        end
      end
      S_TE_FIN: begin
        cmd_o.op = OP_SE_FIN;
        if (status_i.is_move) begin
          state_d = S_MV0;
        end else if (status_i.is_rebuild) begin
          state_d = S_RB0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MV0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = MS_STEP_ST;
        state_d      = S_MV1;
      end
      S_MV1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.msel      = MS_STEP_CT;
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd0;
        state_d         = S_MV2;
      end
      S_MV2: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.msel      = MS_STEP_SP;
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd1;
        state_d         = S_MV3;
      end
      S_MV3: begin
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd2;
        state_d         = S_MV_APPLY;
      end
      S_MV_APPLY: begin
        cmd_o.op = OP_MOVE;
        state_d  = S_OUT;
      end
      S_RB0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = MS_DIST_SP;
        state_d      = S_RB1;
      end
      S_RB1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.msel      = MS_DIST_CP;
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd0;
        state_d         = S_RB2;
      end
      S_RB2: begin
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd1;
        state_d         = S_RB3;
      end
      S_RB3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = MS_COSP_CT;
        state_d      = S_RB4;
      end
      S_RB4: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.msel      = MS_COSP_ST;
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd2;
        state_d         = S_RB5;
      end
      S_RB5: begin
        cmd_o.save_en   = 1'b1;
        cmd_o.save_slot = 2'd3;
        state_d         = S_RB_APPLY;
      end
      S_RB_APPLY: begin
        cmd_o.op = OP_REBUILD;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SCC_ASSERT_NEXT(a_accept_dispatch, in_accept, state_q == S_DISP)
  `SCC_ASSERT_NEXT(a_out_after_issue, cmd_o.op == OP_OUT, out_valid_q && state_q == S_IDLE)
  `SCC_ASSERT_NEXT(a_iter_holds, state_q == S_TA_ITER && !status_i.iter_last,
                   state_q == S_TA_ITER)

endmodule

// File: rtl/scc_datapath.sv
// ---------------------------------------------------------------------------
// Spherical camera controller datapath
// Camera state, shared CORDIC, shared multiplier and the result register.
// ---------------------------------------------------------------------------
module scc_datapath
  import scc_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  cmd_item_t   item_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output res_item_t   res_o
);

  localparam int ITERS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;

  logic [4:0]         func_q;
  logic signed [31:0] step_q;
  logic [31:0]        crd_q [3];
  logic [31:0]        eye_q [3];
  logic [31:0]        tgt_q [3];
  logic [31:0]        dist_q;
  logic signed [15:0] elev_q, azim_q;
  logic [15:0]        limit_q;

  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q, t24_q;
  logic [4:0]           it_q;
  logic                 vec_q, neg_q;
  logic [35:0]          nn_q;

  logic signed [PW-1:0] prod_q;
  logic                 sh24_q;
  logic signed [RW-1:0] res_q [4];
  logic signed [15:0]   st_q, ct_q, sp_q, cp_q;
  res_item_t            out_q;

  // Coordinate differences
  logic signed [32:0] dx, dy, dz;
  logic signed [33:0] dx_abs;
  assign dx = $signed({eye_q[0][31], eye_q[0]}) - $signed({tgt_q[0][31], tgt_q[0]});
  assign dy = $signed({eye_q[1][31], eye_q[1]}) - $signed({tgt_q[1][31], tgt_q[1]});
  assign dz = $signed({eye_q[2][31], eye_q[2]}) - $signed({tgt_q[2][31], tgt_q[2]});
  assign dx_abs = dx[32] ? -$signed({dx[32], dx}) : $signed({dx[32], dx});

  logic signed [XW-1:0] v1x, v1y, v2x, v2y;
  assign v1x = $signed({{(XW-34){dx_abs[33]}}, dx_abs}) <<< 16;
  assign v1y = $signed({{(XW-33){dz[32]}}, dz}) <<< 16;
  assign v2y = $signed({{(XW-33){dy[32]}}, dy}) <<< 16;

  // Rounded product
  logic signed [PW-1:0] prod_sh;
  logic signed [RW-1:0] rnd;
  assign prod_sh = sh24_q ? ((prod_q + 62'sd8388608) >>> 24) : ((prod_q + 62'sd8192) >>> 14);
  assign rnd     = prod_sh[RW-1:0];
  assign v2x     = $signed({{(XW-36){1'b0}}, rnd[35:0]}) <<< 16;

  // CORDIC iteration
  logic signed [XW-1:0] xs, ys, x_it, y_it;
  logic signed [ZW-1:0] z_it, at;
  logic                 dirp;
  assign xs   = x_q >>> it_q;
  assign ys   = y_q >>> it_q;
  assign at   = atan_lut(it_q);
  assign dirp = vec_q ? ~y_q[XW-1] : z_q[ZW-1];
  assign x_it = dirp ? x_q + ys : x_q - ys;
  assign y_it = dirp ? y_q - xs : y_q + xs;
  assign z_it = dirp ? z_q + at : z_q - at;

  // Sine and cosine start angle
  logic signed [15:0]   ang;
  logic signed [ZW-1:0] zin, zfold;
  logic                 zneg;
  assign ang = (cmd_i.op == OP_SE_INIT) ? elev_q : azim_q;
  assign zin = $signed({{(ZW-16){ang[15]}}, ang}) <<< 11;
  always_comb begin
    zfold = zin;
    zneg  = 1'b0;
    if (zin > HALF_PI_Q24) begin
      zfold = zin - PI_Q24;
      zneg  = 1'b1;
    end else if (zin < -HALF_PI_Q24) begin
      zfold = zin + PI_Q24;
      zneg  = 1'b1;
    end
  end

  function automatic logic signed [15:0] trig_fin(input logic signed [XW-1:0] v,
                                                  input logic neg);
    logic signed [XW-1:0] r;
    logic signed [15:0]   c;
    r = (v + 58'sd32768) >>> 16;
    if (r > ONE_Q14) begin
      r = ONE_Q14;
    end else if (r < -ONE_Q14) begin
      r = -ONE_Q14;
    end
    c = r[15:0];
    return neg ? -c : c;
  endfunction

  // Shared multiplier
  logic signed [XW-1:0]  xpos, xr;
  logic signed [MAW-1:0] ma, cosp_abs;
  logic signed [MBW-1:0] mb;
  assign xpos     = x_q[XW-1] ? '0 : x_q;
  assign xr       = (xpos + 58'sd32768) >>> 16;
  assign cosp_abs = res_q[1][RW-1] ? -res_q[1][MAW-1:0] : res_q[1][MAW-1:0];

  always_comb begin
    ma = $signed({{(MAW-32){step_q[31]}}, step_q});
    mb = INVK_Q24;
    case (cmd_i.msel)
      MS_UNSCALE: begin
        ma = xr[MAW-1:0];
        mb = INVK_Q24;
      end
      MS_STEP_ST: mb = $signed({{(MBW-16){st_q[15]}}, st_q});
      MS_STEP_CT: mb = $signed({{(MBW-16){ct_q[15]}}, ct_q});
      MS_STEP_SP: mb = $signed({{(MBW-16){sp_q[15]}}, sp_q});
      MS_DIST_SP: begin
        ma = $signed({{(MAW-32){1'b0}}, dist_q});
        mb = $signed({{(MBW-16){sp_q[15]}}, sp_q});
      end
      MS_DIST_CP: begin
        ma = $signed({{(MAW-32){1'b0}}, dist_q});
        mb = $signed({{(MBW-16){cp_q[15]}}, cp_q});
      end
      MS_COSP_CT: begin
        ma = cosp_abs;
        mb = $signed({{(MBW-16){ct_q[15]}}, ct_q});
      end
      MS_COSP_ST: begin
        ma = cosp_abs;
        mb = $signed({{(MBW-16){st_q[15]}}, st_q});
      end
      default: ;
    endcase
  end

  // Refresh angles
  logic signed [ZW-1:0] pr, tr;
  logic signed [19:0]   pf, tf;
  logic                 near;
  assign pr   = (z_q + 30'sd1024) >>> 11;
  assign tr   = (t24_q + 30'sd1024) >>> 11;
  assign near = (nn_q < {20'd0, limit_q});
  always_comb begin
    pf = pr[19:0];
    tf = tr[19:0];
    if (dz[32]) begin
      pf = pf[19] ? -PI_Q13 - pf : PI_Q13 - pf;
    end
    if (dx[32]) begin
      tf = tf[19] ? -PI_Q13 - tf : PI_Q13 - tf;
    end
  end

  // Move and rebuild offsets
  logic [2:0]  kind;
  logic        mv_eye;
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] d0, d1, d2, e0, e1, e2;
  assign mv_eye = (func_q < FN_TGT_LO);
  assign kind   = mv_eye ? 3'(func_q - FN_EYE_LO) : 3'(func_q - FN_TGT_LO);
  assign ra     = res_q[0][31:0];
  assign rb     = res_q[1][31:0];
  assign rc     = res_q[2][31:0];
  assign rd     = res_q[3][31:0];
  always_comb begin
    if (kind < 3'd2) begin
      d0 = ra;
      d1 = '0;
      d2 = -rb;
    end else begin
      d0 = -rb;
      d1 = (kind >= 3'd4) ? -rc : '0;
      d2 = -ra;
    end
    e0 = kind[0] ? -d0 : d0;
    e1 = kind[0] ? -d1 : d1;
    e2 = kind[0] ? -d2 : d2;
  end

  assign status_o.iter_last  = (it_q == 5'(ITERS - 1));
  assign status_o.is_load    = (func_q < FN_REFRESH);
  assign status_o.is_refresh = (func_q == FN_REFRESH);
  assign status_o.is_move    = (func_q >= FN_EYE_LO) && (func_q <= FN_TGT_HI);
  assign status_o.is_rebuild = (func_q == FN_FPS) || (func_q == FN_TPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        eye_q[i] <= '0;
        tgt_q[i] <= '0;
      end
      dist_q  <= '0;
      elev_q  <= '0;
      azim_q  <= '0;
      limit_q <= 16'd1;
      func_q  <= '0;
      it_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      case (cmd_i.op)
        OP_CAPTURE: begin
          func_q   <= item_i.func;
          step_q   <= item_i.step;
          crd_q[0] <= item_i.coord_x;
          crd_q[1] <= item_i.coord_y;
          crd_q[2] <= item_i.coord_z;
        end
        OP_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            if (func_q[0]) begin
              tgt_q[i] <= crd_q[i];
            end else begin
              eye_q[i] <= crd_q[i];
            end
          end
        end
        OP_V1_INIT: begin
          x_q   <= v1x;
          y_q   <= v1y;
          z_q   <= '0;
          it_q  <= '0;
          vec_q <= 1'b1;
        end
        OP_V2_INIT: begin
          nn_q  <= rnd[35:0];
          x_q   <= v2x;
          y_q   <= v2y;
          z_q   <= '0;
          it_q  <= '0;
          vec_q <= 1'b1;
        end
        OP_ITER: begin
          x_q  <= x_it;
          y_q  <= y_it;
          z_q  <= z_it;
          it_q <= it_q + 5'd1;
        end
        OP_SAVE_T: t24_q <= z_q;
        OP_REFRESH: begin
          dist_q <= (rnd[RW-1:32] != '0) ? 32'hFFFF_FFFF : rnd[31:0];
          if (near) begin
            elev_q <= dy[32] ? -HALF_PI_Q13 : HALF_PI_Q13;
            azim_q <= '0;
          end else begin
            elev_q <= pf[15:0];
            azim_q <= tf[15:0];
          end
        end
        OP_SA_INIT, OP_SE_INIT: begin
          x_q   <= INVK_Q30;
          y_q   <= '0;
          z_q   <= zfold;
          neg_q <= zneg;
          it_q  <= '0;
          vec_q <= 1'b0;
        end
        OP_SA_FIN: begin
          st_q <= trig_fin(y_q, neg_q);
          ct_q <= trig_fin(x_q, neg_q);
        end
        OP_SE_FIN: begin
          sp_q <= trig_fin(y_q, neg_q);
          cp_q <= trig_fin(x_q, neg_q);
        end
        OP_MOVE: begin
          if (mv_eye) begin
            eye_q[0] <= eye_q[0] + e0;
            eye_q[1] <= eye_q[1] + e1;
            eye_q[2] <= eye_q[2] + e2;
          end else begin
            tgt_q[0] <= tgt_q[0] + e0;
            tgt_q[1] <= tgt_q[1] + e1;
            tgt_q[2] <= tgt_q[2] + e2;
          end
        end
        OP_REBUILD: begin
          if (func_q == FN_FPS) begin
            tgt_q[0] <= eye_q[0] - rc;
            tgt_q[1] <= eye_q[1] - ra;
            tgt_q[2] <= eye_q[2] - rd;
          end else begin
            eye_q[0] <= tgt_q[0] + rc;
            eye_q[1] <= tgt_q[1] + ra;
            eye_q[2] <= tgt_q[2] + rd;
          end
        end
        OP_OUT: begin
          out_q.eye_x         <= eye_q[0];
          out_q.eye_y         <= eye_q[1];
          out_q.eye_z         <= eye_q[2];
          out_q.target_x      <= tgt_q[0];
          out_q.target_y      <= tgt_q[1];
          out_q.target_z      <= tgt_q[2];
          out_q.view_range    <= dist_q;
          out_q.elevation_out <= elev_q;
          out_q.azimuth_out   <= azim_q;
          out_q.dir_x         <= -ct_q;
          out_q.dir_y         <= -sp_q;
          out_q.dir_z         <= -st_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
      sh24_q <= (cmd_i.msel == MS_UNSCALE);
    end
    if (cmd_i.save_en) begin
      res_q[cmd_i.save_slot] <= rnd;
    end
  end

  assign res_o = out_q;

endmodule

// File: rtl/spherical_camera_controller.sv
// ---------------------------------------------------------------------------
// Spherical camera controller
// Eye and look-at points with distance, elevation and azimuth, driven by
// command words and reported after each one.
//
//   channel  dir  handshake      payload
//   cmd_i    in   valid/ready    func, step, coord_x, coord_y, coord_z
//   res_o    out  valid/ready    positions, view_range, angles, dir_x/y/z
//   cfg_i    in   valid/ready    near_axis_limit (16 bits)
//
// With N = min(CORDIC_ITERATIONS, 24), each CORDIC pass runs N iterations.
// Loads, refreshes, moves and rebuilds all run on the shared CORDIC;
// refreshes, moves and rebuilds also use the shared multiplier.
// One word is in work at a time; a result waits in the output register
// while the next word is taken. Reset clears all points and angles.
// ---------------------------------------------------------------------------
module spherical_camera_controller
  import scc_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  scc_cmd_if.sink  cmd_i,
  scc_res_if.source res_o,
  scc_cfg_if.sink  cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  cmd_item_t  item;
  res_item_t  res;

  assign cfg_i.ready = 1'b1;

  assign item.func    = cmd_i.func;
  assign item.step    = cmd_i.step;
  assign item.coord_x = cmd_i.coord_x;
  assign item.coord_y = cmd_i.coord_y;
  assign item.coord_z = cmd_i.coord_z;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  scc_datapath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .item_i     (item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .res_o      (res)
  );

  assign res_o.eye_x         = res.eye_x;
  assign res_o.eye_y         = res.eye_y;
  assign res_o.eye_z         = res.eye_z;
  assign res_o.target_x      = res.target_x;
  assign res_o.target_y      = res.target_y;
  assign res_o.target_z      = res.target_z;
  assign res_o.view_range    = res.view_range;
  assign res_o.elevation_out = res.elevation_out;
  assign res_o.azimuth_out   = res.azimuth_out;
  assign res_o.dir_x         = res.dir_x;
  assign res_o.dir_y         = res.dir_y;
  assign res_o.dir_z         = res.dir_z;

endmodule

// File: sim/scc_tb_if.sv
// ---------------------------------------------------------------------------
// Testbench channel note
// The block's channel interfaces live with the RTL; this file only holds
// the word record used between the testbench's stimulus and its driver.
// ---------------------------------------------------------------------------
package scc_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit         is_cfg;
    logic [15:0] cfg_data;
    logic [4:0]  func;
    logic [31:0] step;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
  } tb_word_t;
endpackage

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// Spherical camera controller testbench
// Drives command words and limit writes with random idling on both sides,
// predicts every result with a fixed-point camera model and compares each
// reported word field by field.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;
  import scc_tb_pkg::*;

  localparam int NITER = 16;
  localparam int NSTEP = (NITER < 24) ? NITER : 24;
  localparam logic [4:0] FN_SET_EYE = 5'd0;
  localparam logic [4:0] FN_SET_TGT = 5'd1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scc_cmd_if cmd ();
  scc_res_if res ();
  scc_cfg_if cfg ();

  spherical_camera_controller #(.CORDIC_ITERATIONS(NITER)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd.sink), .res_o(res.source), .cfg_i(cfg.sink)
  );

  // Camera model state.
  logic [31:0] cam_eye [3];
  logic [31:0] cam_tgt [3];
  logic [31:0] cam_range;
  int          cam_elev;
  int          cam_azim;
  int          cam_limit;

  res_item_t   expected_q [$];
  tb_word_t    pending_q [$];
  int          errors = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  bit          calm = 1'b0;
  bit          hold = 1'b0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint atan_of(int i);
    return longint'(atan_lut(i[4:0]));
  endfunction

  function automatic longint vector_mag(longint x0, longint y0, output longint ang);
    longint x, y, z, xs, ys;
    x = x0; y = y0; z = 0;
    for (int i = 0; i < NSTEP; i++) begin
      xs = asr(x, i); ys = asr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_of(i);
      end else begin
        x -= ys; y += xs; z -= atan_of(i);
      end
    end
    ang = z;
    return x < 0 ? 0 : x;
  endfunction

  function automatic longint gain_fix(longint m);
    return rnd_shift(rnd_shift(m, 16) * 64'sd10188014, 24);
  endfunction

  function automatic longint clip14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  task automatic trig(input int a13, output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit neg;
    z = longint'(a13) * 2048; x = 652032874; y = 0; neg = 0;
    if (z > 26353589) begin
      z -= 52707179; neg = 1;
    end else if (z < -26353589) begin
      z += 52707179; neg = 1;
    end
    for (int i = 0; i < NSTEP; i++) begin
      xs = asr(x, i); ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_of(i);
      end else begin
        x += ys; y -= xs; z += atan_of(i);
      end
    end
    x = clip14(rnd_shift(x, 16));
    y = clip14(rnd_shift(y, 16));
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint mul14(longint a, longint t);
    return rnd_shift(a * t, 14);
  endfunction

  task automatic refresh_angles();
    longint dx, dy, dz, t24, p24, nn, span, p, t;
    dx = sx32(cam_eye[0]) - sx32(cam_tgt[0]);
    dy = sx32(cam_eye[1]) - sx32(cam_tgt[1]);
    dz = sx32(cam_eye[2]) - sx32(cam_tgt[2]);
    nn = gain_fix(vector_mag((dx < 0 ? -dx : dx) * 65536, dz * 65536, t24));
    span = gain_fix(vector_mag(nn * 65536, dy * 65536, p24));
    cam_range = span > 64'hFFFFFFFF ? 32'hFFFFFFFF : span[31:0];
    if (nn < cam_limit) begin
      cam_elev = dy >= 0 ? 12868 : -12868;
      cam_azim = 0;
    end else begin
      p = rnd_shift(p24, 11);
      t = rnd_shift(t24, 11);
      if (dz < 0) p = p >= 0 ? 25736 - p : -25736 - p;
      if (dx < 0) t = t >= 0 ? 25736 - t : -25736 - t;
      cam_elev = int'(p);
      cam_azim = int'(t);
    end
  endtask

  task automatic move_pt(inout logic [31:0] pt [3], input int kind, input longint st_len);
    longint st, ct, sp, cp;
    longint d [3];
    trig(cam_azim, st, ct);
    trig(cam_elev, sp, cp);
    if (kind < 2) begin
      d[0] = mul14(st_len, st); d[1] = 0; d[2] = -mul14(st_len, ct);
    end else begin
      d[0] = -mul14(st_len, ct);
      d[1] = kind >= 4 ? -mul14(st_len, sp) : 0;
      d[2] = -mul14(st_len, st);
    end
    for (int i = 0; i < 3; i++) begin
      if (kind % 2 == 1) d[i] = -d[i];
      pt[i] = 32'(sx32(pt[i]) + d[i]);
    end
  endtask

  task automatic rebuild_pt(output logic [31:0] dst [3], input logic [31:0] src [3],
                            input longint sgn);
    longint st, ct, sp, cp, sinp, cosp, span;
    span = longint'(cam_range);
    trig(cam_azim, st, ct);
    trig(cam_elev, sp, cp);
    sinp = mul14(span, sp);
    cosp = mul14(span, cp);
    if (cosp < 0) cosp = -cosp;
    dst[0] = 32'(sx32(src[0]) + sgn * mul14(cosp, ct));
    dst[1] = 32'(sx32(src[1]) + sgn * sinp);
    dst[2] = 32'(sx32(src[2]) + sgn * mul14(cosp, st));
  endtask

  task automatic camera_apply(input tb_word_t w);
    res_item_t r;
    longint st, ct, sp, cp;
    logic [31:0] tmp [3];
    case (w.func) inside
      FN_SET_EYE: begin
        cam_eye[0] = w.cx; cam_eye[1] = w.cy; cam_eye[2] = w.cz;
      end
      FN_SET_TGT: begin
        cam_tgt[0] = w.cx; cam_tgt[1] = w.cy; cam_tgt[2] = w.cz;
      end
      FN_REFRESH: refresh_angles();
      [FN_EYE_LO:FN_TGT_LO-1]: move_pt(cam_eye, int'(w.func - FN_EYE_LO), sx32(w.step));
      [FN_TGT_LO:FN_TGT_HI]: move_pt(cam_tgt, int'(w.func - FN_TGT_LO), sx32(w.step));
      FN_FPS: begin
        rebuild_pt(tmp, cam_eye, -1);
        cam_tgt = tmp;
      end
      FN_TPS: begin
        rebuild_pt(tmp, cam_tgt, 1);
        cam_eye = tmp;
      end
      default: ;
    endcase
    r.eye_x = cam_eye[0]; r.eye_y = cam_eye[1]; r.eye_z = cam_eye[2];
    r.target_x = cam_tgt[0]; r.target_y = cam_tgt[1]; r.target_z = cam_tgt[2];
    r.view_range = cam_range;
    r.elevation_out = 16'(cam_elev);
    r.azimuth_out = 16'(cam_azim);
    trig(cam_azim, st, ct);
    trig(cam_elev, sp, cp);
    r.dir_x = 16'(-ct);
    r.dir_y = 16'(-sp);
    r.dir_z = 16'(-st);
    expected_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout after %0d results", results_seen);
    $display("testbench: done, errors");
    $finish;
  end

  // Driver: one word in flight per channel; configuration only when idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd.valid <= 1'b0; cmd.func <= '0; cmd.step <= '0;
      cmd.coord_x <= '0; cmd.coord_y <= '0; cmd.coord_z <= '0;
      cfg.valid <= 1'b0; cfg.data <= '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        tb_word_t w;
        w = pending_q.pop_front();
        camera_apply(w);
        words_sent++;
      end
      if (cfg.valid && cfg.ready) begin
        tb_word_t w;
        w = pending_q.pop_front();
        cam_limit = int'(w.cfg_data);
      end
      if ((cmd.valid && !cmd.ready) || (cfg.valid && !cfg.ready)) begin
      end else if (pending_q.size() > 0 && !(cmd.valid && cmd.ready)
                   && !(cfg.valid && cfg.ready) && !hold
                   && (calm || $urandom_range(99) >= 28)) begin
        if (pending_q[0].is_cfg) begin
          cmd.valid <= 1'b0;
          if (expected_q.size() == 0) begin
            cfg.valid <= 1'b1; cfg.data <= pending_q[0].cfg_data;
          end
        end else begin
          cfg.valid <= 1'b0;
          cmd.valid <= 1'b1; cmd.func <= pending_q[0].func; cmd.step <= pending_q[0].step;
          cmd.coord_x <= pending_q[0].cx; cmd.coord_y <= pending_q[0].cy;
          cmd.coord_z <= pending_q[0].cz;
        end
      end else begin
        cmd.valid <= 1'b0;
        cfg.valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res_item_t w;
        results_seen++;
        if (expected_q.size() == 0) begin
          report("unexpected result word", 64'(res.eye_x), 64'd0);
        end else begin
          w = expected_q.pop_front();
          if (res.eye_x !== w.eye_x) report("eye_x", res.eye_x, w.eye_x);
          if (res.eye_y !== w.eye_y) report("eye_y", res.eye_y, w.eye_y);
          if (res.eye_z !== w.eye_z) report("eye_z", res.eye_z, w.eye_z);
          if (res.target_x !== w.target_x) report("target_x", res.target_x, w.target_x);
          if (res.target_y !== w.target_y) report("target_y", res.target_y, w.target_y);
          if (res.target_z !== w.target_z) report("target_z", res.target_z, w.target_z);
          if (res.view_range !== w.view_range)
            report("view_range", res.view_range, w.view_range);
          if (res.elevation_out !== w.elevation_out)
            report("elevation", res.elevation_out, w.elevation_out);
          if (res.azimuth_out !== w.azimuth_out)
            report("azimuth", res.azimuth_out, w.azimuth_out);
          if (res.dir_x !== w.dir_x) report("dir_x", res.dir_x, w.dir_x);
          if (res.dir_y !== w.dir_y) report("dir_y", res.dir_y, w.dir_y);
          if (res.dir_z !== w.dir_z) report("dir_z", res.dir_z, w.dir_z);
        end
      end
      res.ready <= calm || $urandom_range(99) >= 28;
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 4;
      default: return 32'($signed($urandom_range(200)) - 100) <<< 16;
    endcase
  endfunction

  function automatic tb_word_t mk(input logic [4:0] f, input logic [31:0] s,
                                  input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z);
    tb_word_t w;
    w.is_cfg = 0; w.cfg_data = '0; w.func = f; w.step = s; w.cx = x; w.cy = y; w.cz = z;
    return w;
  endfunction

  task automatic add_limit(input logic [15:0] v);
    tb_word_t w;
    w = mk(0, 0, 0, 0, 0);
    w.is_cfg = 1; w.cfg_data = v;
    pending_q.push_back(w);
  endtask

  task automatic add_random(input int n);
    logic [4:0] f;
    logic [31:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: f = FN_SET_EYE;
        1: f = FN_SET_TGT;
        2, 3: f = FN_REFRESH;
        4: f = 5'($urandom_range(31));
        default: f = 5'($urandom_range(16));
      endcase
      s = ($urandom_range(4) == 0) ? $urandom
                                   : 32'($signed($urandom_range(40000000)) - 20000000);
      pending_q.push_back(mk(f, s, rnd_coord(), rnd_coord(), rnd_coord()));
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || expected_q.size() > 0 || cmd.valid) @(posedge clk_i);
  endtask

  initial begin
    cam_eye = '{0, 0, 0}; cam_tgt = '{0, 0, 0};
    cam_range = 0; cam_elev = 0; cam_azim = 0; cam_limit = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every function, vertical and coincident cases.
    pending_q.push_back(mk(FN_REFRESH, 0, 0, 0, 0));
    pending_q.push_back(mk(FN_SET_EYE, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF));
    pending_q.push_back(mk(FN_SET_TGT, 0, 32'h80000000, 32'h7FFFFFFF, 32'h00000001));
    pending_q.push_back(mk(FN_REFRESH, 0, 0, 0, 0));
    pending_q.push_back(mk(FN_SET_EYE, 0, 0, 32'h000A0000, 0));
    pending_q.push_back(mk(FN_SET_TGT, 0, 0, 0, 0));
    pending_q.push_back(mk(FN_REFRESH, 0, 0, 0, 0));
    pending_q.push_back(mk(FN_SET_EYE, 0, 0, 32'hFFF60000, 0));
    pending_q.push_back(mk(FN_REFRESH, 0, 0, 0, 0));
    pending_q.push_back(mk(FN_SET_EYE, 0, 32'hFFFB0000, 32'h00030000, 32'hFFFC0000));
    pending_q.push_back(mk(FN_REFRESH, 0, 0, 0, 0));
    for (int f = 3; f <= 16; f++)
      pending_q.push_back(mk(5'(f), (f % 2) ? 32'h7FFFFFFF : 32'h80000000, 0, 0, 0));
    pending_q.push_back(mk(5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    wait_idle();
    repeat (100) @(posedge clk_i);

    add_limit(16'hFFFF);
    add_random(300);
    // Hold the sender partway through until every result is back.
    while (pending_q.size() > 150) @(posedge clk_i);
    hold = 1'b1;
    while (expected_q.size() > 0 || cmd.valid) @(posedge clk_i);
    hold = 1'b0;
    wait_idle();
    repeat (100) @(posedge clk_i);
    add_limit(16'h0000);
    add_random(300);
    wait_idle();
    repeat (100) @(posedge clk_i);
    calm = 1'b1;
    add_limit(16'h8000);
    add_random(350);
    wait_idle();
    calm = 1'b0;
    repeat (100) @(posedge clk_i);
    add_limit(16'h0001);
    add_random(700);
    wait_idle();
    repeat (200) @(posedge clk_i);

    $display("covered %0d command words and %0d results over four limit settings",
             words_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, expected_q.size());
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_if.sv
rtl/scc_ctrl.sv
rtl/scc_datapath.sv
rtl/spherical_camera_controller.sv
sim/scc_tb_if.sv
sim/testbench.sv
